>>> design/lsa_pkg.sv
// ----------------------------------------------------------------------------
// lsa_pkg
// Shared constants and types of the lidar sector averager.
// ----------------------------------------------------------------------------
`default_nettype none
package lsa_pkg;

  localparam int SAMPLES_PER_SCAN = 360;
  localparam int NUM_SECTORS      = 8;

  localparam int SPAN_RAW    = SAMPLES_PER_SCAN / NUM_SECTORS;
  localparam int SECTOR_SPAN = (SPAN_RAW == 0) ? 1 : SPAN_RAW;
  // the last sector also takes the leftover samples
  localparam int LAST_SPAN   = (SPAN_RAW == 0) ? 1 :
                               SAMPLES_PER_SCAN - (NUM_SECTORS - 1) * SECTOR_SPAN;

  localparam int DIST_W = 16;
  localparam int IDX_W  = 3;
  localparam int POS_W  = $clog2(SAMPLES_PER_SCAN);
  localparam int SEC_W  = (NUM_SECTORS > 1) ? $clog2(NUM_SECTORS) : 1;
  localparam int OFS_W  = $clog2(SECTOR_SPAN + 1);
  localparam int CNT_W  = $clog2(LAST_SPAN + 1);
  localparam int SUM_W  = CNT_W + DIST_W;
  localparam int BIT_W  = $clog2(SUM_W + 1);

  localparam logic [DIST_W-1:0] MARKER_RESET = 16'hFFFF;

  typedef struct packed {
    logic [IDX_W-1:0]  sector;
    logic [SUM_W-1:0]  sum;
    logic [CNT_W-1:0]  count;
    logic              last;
    logic [DIST_W-1:0] marker;
  } lsa_job_t;

endpackage
`default_nettype wire

>>> design/lsa_if.sv
// ----------------------------------------------------------------------------
// lsa_if
// Valid/ready channels for samples and sector results.
// ----------------------------------------------------------------------------
`default_nettype none
interface lsa_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] distance_mm;
  modport source (output valid, output distance_mm, input ready);
  modport sink   (input valid, input distance_mm, output ready);
endinterface

interface lsa_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  sector_index;
  logic [15:0] average_mm;
  logic        last_sector;
  modport source (output valid, output sector_index, output average_mm,
                  output last_sector, input ready);
  modport sink   (input valid, input sector_index, input average_mm,
                  input last_sector, output ready);
endinterface
`default_nettype wire

>>> design/lsa_front.sv
// ----------------------------------------------------------------------------
// lsa_front
// Tracks scan position, accumulates valid samples and closes sectors.
// ----------------------------------------------------------------------------
`default_nettype none
module lsa_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [lsa_pkg::DIST_W-1:0]   cfg_data,
  input  wire logic                         in_valid,
  output      logic                         in_ready,
  input  wire logic [lsa_pkg::DIST_W-1:0]   in_distance,
  output      logic                         push_valid,
  input  wire logic                         push_ready,
  output      lsa_pkg::lsa_job_t            push_job
);
  import lsa_pkg::*;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [OFS_W-1:0]  ofs_r, ofs_nxt;
  logic [SEC_W-1:0]  sec_r, sec_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIST_W-1:0] marker_r;
  logic [SUM_W-1:0]  sum_acc;
  logic [CNT_W-1:0]  cnt_acc;
  logic              hit, scan_end, sector_end, take;

  assign in_ready = push_ready;
  assign take     = in_valid && in_ready;
  assign hit      = (in_distance != marker_r);
  assign scan_end = (pos_r == POS_W'(SAMPLES_PER_SCAN - 1));
  assign sector_end = scan_end ||
                      ((ofs_r == OFS_W'(SECTOR_SPAN - 1)) &&
                       (sec_r != SEC_W'(NUM_SECTORS - 1)));

  assign sum_acc = hit ? sum_r + SUM_W'(in_distance) : sum_r;
  assign cnt_acc = hit ? cnt_r + CNT_W'(1) : cnt_r;

  assign push_valid      = take && sector_end;
  assign push_job.sector = IDX_W'(sec_r);
  assign push_job.sum    = sum_acc;
  assign push_job.count  = cnt_acc;
  assign push_job.last   = scan_end;
  assign push_job.marker = marker_r;

  always_comb begin
    pos_nxt = pos_r;
    ofs_nxt = ofs_r;
    sec_nxt = sec_r;
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (take) begin
      if (scan_end) begin
        pos_nxt = '0;
        ofs_nxt = '0;
        sec_nxt = '0;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
        if (sector_end) begin
          ofs_nxt = '0;
          sec_nxt = sec_r + SEC_W'(1);
        end else begin
          ofs_nxt = ofs_r + OFS_W'(1);
        end
      end
      // clear the accumulator once the sector is handed off
      if (sector_end) begin
        sum_nxt = '0;
        cnt_nxt = '0;
      end else begin
        sum_nxt = sum_acc;
        cnt_nxt = cnt_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      ofs_r    <= '0;
      sec_r    <= '0;
      sum_r    <= '0;
      cnt_r    <= '0;
      marker_r <= MARKER_RESET;
    end else begin
      pos_r <= pos_nxt;
      ofs_r <= ofs_nxt;
      sec_r <= sec_nxt;
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
      if (cfg_we) begin
        marker_r <= cfg_data;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/lsa_queue.sv
// ----------------------------------------------------------------------------
// lsa_queue
// Two-entry queue of closed sectors between front and divider.
// ----------------------------------------------------------------------------
`default_nettype none
module lsa_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  output      logic              push_ready,
  input  wire lsa_pkg::lsa_job_t push_job,
  output      logic              pop_valid,
  input  wire logic              pop_ready,
  output      lsa_pkg::lsa_job_t pop_job
);
  import lsa_pkg::*;

  lsa_job_t   mem_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       do_push, do_pop;

  assign push_ready = (fill_r != 2'd2);
  assign pop_valid  = (fill_r != 2'd0);
  assign pop_job    = mem_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_nxt   = do_push ? ~wr_r : wr_r;
    rd_nxt   = do_pop ? ~rd_r : rd_r;
    fill_nxt = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= 1'b0;
      rd_r   <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      wr_r   <= wr_nxt;
      rd_r   <= rd_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/lsa_divider.sv
// ----------------------------------------------------------------------------
// lsa_divider
// Restoring divider, one quotient bit per cycle, with a result register.
// ----------------------------------------------------------------------------
`default_nettype none
module lsa_divider (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              job_valid,
  output      logic              job_ready,
  input  wire lsa_pkg::lsa_job_t job,
  lsa_out_if.source              out_ch
);
  import lsa_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  den_r, den_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              last_r, last_nxt;
  logic [DIST_W-1:0] avg_r, avg_nxt;
  logic [CNT_W:0]    trial;
  logic              fits;

  assign job_ready = (state_r == ST_IDLE);
  assign trial     = {rem_r, quo_r[SUM_W-1]};
  assign fits      = (trial >= {1'b0, den_r});

  assign out_ch.valid        = (state_r == ST_DONE);
  assign out_ch.sector_index = idx_r;
  assign out_ch.average_mm   = avg_r;
  assign out_ch.last_sector  = last_r;

  always_comb begin
    state_nxt = state_r;
    bit_nxt   = bit_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    den_nxt   = den_r;
    idx_nxt   = idx_r;
    last_nxt  = last_r;
    avg_nxt   = avg_r;
    case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          idx_nxt  = job.sector;
          last_nxt = job.last;
          den_nxt  = job.count;
          quo_nxt  = job.sum;
          rem_nxt  = '0;
          bit_nxt  = BIT_W'(SUM_W);
          if (job.count == '0) begin
            avg_nxt   = job.marker;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_BUSY;
          end
        end
      end
      ST_BUSY: begin
        // the partial remainder stays below the divisor
        rem_nxt = fits ? CNT_W'(trial - {1'b0, den_r}) : trial[CNT_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], fits};
        bit_nxt = bit_r - BIT_W'(1);
        if (bit_r == BIT_W'(1)) begin
          avg_nxt   = quo_nxt[DIST_W-1:0];
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    bit_r  <= bit_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    den_r  <= den_nxt;
    idx_r  <= idx_nxt;
    last_r <= last_nxt;
    avg_r  <= avg_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/lidar_sector_averager_core.sv
// ----------------------------------------------------------------------------
// lidar_sector_averager_core
// Per-sector truncating average of lidar distance samples over a scan.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle while the two-entry queue has room.
// A closed sector goes through the queue into a restoring divider that
// loads it, works out all SUM_W quotient bits (22 at default) and holds the
// result until taken; an empty sector yields the marker without dividing.
// Synchronous active-low reset clears position and sums and sets the invalid
// marker to 0xFFFF.
`default_nettype none
module lidar_sector_averager_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [15:0]  cfg_data,
  lsa_in_if.sink            in_chan,
  lsa_out_if.source         out_chan
);
  import lsa_pkg::*;

  logic     push_valid, push_ready;
  lsa_job_t push_job;
  logic     pop_valid, pop_ready;
  lsa_job_t pop_job;

  lsa_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_valid    (in_chan.valid),
    .in_ready    (in_chan.ready),
    .in_distance (in_chan.distance_mm),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_job    (push_job)
  );

  lsa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  lsa_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (pop_valid),
    .job_ready (pop_ready),
    .job       (pop_job),
    .out_ch    (out_chan)
  );

endmodule
`default_nettype wire

>>> test/sector_average_checker.sv
// ----------------------------------------------------------------------------
// sector_average_checker
// Watches the sample, result and marker ports of the sector averager. It keeps
// its own scan position, per-sector sum and count, and predicts every sector
// average, then compares each delivered result against the oldest prediction.
// ----------------------------------------------------------------------------
module sector_average_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  lsa_in_if           in_chan,
  lsa_out_if          out_chan,
  output int          fail_count,
  output int          pending
);

  localparam int unsigned SPAN_RAW = lsa_pkg::SAMPLES_PER_SCAN / lsa_pkg::NUM_SECTORS;
  localparam int unsigned SPAN     = (SPAN_RAW == 0) ? 1 : SPAN_RAW;

  typedef struct packed {
    logic [2:0]  sector_index;
    logic [15:0] average_mm;
    logic        last_sector;
  } sector_result_t;

  sector_result_t sector_results_due[$];

  int unsigned scan_pos;
  logic [31:0] valid_sum;
  logic [31:0] valid_count;
  logic [15:0] marker;
  int          errs;

  initial begin
    errs       = 0;
    fail_count = 0;
    pending    = 0;
  end

  function automatic int unsigned sector_of(input int unsigned pos);
    int unsigned s;
    s = pos / SPAN;
    if (s >= lsa_pkg::NUM_SECTORS) s = lsa_pkg::NUM_SECTORS - 1;
    return s;
  endfunction

  always @(posedge clk) begin : watch
    sector_result_t want;
    sector_result_t got;
    int unsigned    pos;
    int unsigned    sec;
    bit             scan_end;
    if (!rst_n) begin
      scan_pos    = 0;
      valid_sum   = '0;
      valid_count = '0;
      marker      = lsa_pkg::MARKER_RESET;
      sector_results_due.delete();
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        pos = (scan_pos >= lsa_pkg::SAMPLES_PER_SCAN) ? 0 : scan_pos;
        sec = sector_of(pos);
        if (in_chan.distance_mm != marker) begin
          valid_sum   = valid_sum + 32'(in_chan.distance_mm);
          valid_count = valid_count + 32'd1;
        end
        scan_end = (pos + 1) >= lsa_pkg::SAMPLES_PER_SCAN;
        scan_pos = scan_end ? 0 : pos + 1;
        // close the sector on its last sample
        if (scan_end || sector_of(pos + 1) != sec) begin
          want.sector_index = sec[2:0];
          want.average_mm   = (valid_count != 0) ? 16'(valid_sum / valid_count) : marker;
          want.last_sector  = scan_end;
          sector_results_due.push_back(want);
          valid_sum   = '0;
          valid_count = '0;
        end
      end
      // new marker applies from the next sample on
      if (cfg_we) marker = cfg_data;
      if (out_chan.valid && out_chan.ready) begin
        got.sector_index = out_chan.sector_index;
        got.average_mm   = out_chan.average_mm;
        got.last_sector  = out_chan.last_sector;
        if (sector_results_due.size() == 0) begin
          $error("unexpected result: sector_index %0d average_mm %0d last_sector %0d",
                 got.sector_index, got.average_mm, got.last_sector);
          errs++;
        end else begin
          want = sector_results_due.pop_front();
          if (got.sector_index !== want.sector_index) begin
            $error("sector_index: expected %0d, got %0d", want.sector_index, got.sector_index);
            errs++;
          end
          if (got.average_mm !== want.average_mm) begin
            $error("average_mm: expected %0d, got %0d", want.average_mm, got.average_mm);
            errs++;
          end
          if (got.last_sector !== want.last_sector) begin
            $error("last_sector: expected %0d, got %0d", want.last_sector, got.last_sector);
            errs++;
          end
        end
      end
    end
    fail_count <= errs;
    pending    <= sector_results_due.size();
  end

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives distance samples and marker writes into the sector averager with
// random idle bursts on both channels, across several marker settings, and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module testbench;

  localparam int SETTLE = lsa_pkg::SUM_W + 10;

  typedef enum {FILL_MIXED, FILL_EMPTY, FILL_EXTREME, FILL_SPARSE, FILL_FINE} fill_mode_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_data;
  int          fail_count;
  int          pending;

  int          sent;
  logic        calm;
  logic [15:0] marker_now;
  int          stall_left;

  lsa_in_if  in_chan();
  lsa_out_if out_chan();

  lidar_sector_averager_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  sector_average_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: stall in random bursts unless calm
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left     <= stall_left - 1;
      out_chan.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      stall_left     <= $urandom_range(0, 2);
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  task automatic send_sample(input logic [15:0] d);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.distance_mm <= d;
    do @(posedge clk); while (!in_chan.ready);
    sent++;
  endtask

  // hold off until every predicted result has been delivered
  task automatic drain();
    in_chan.valid <= 1'b0;
    // let the count catch up with the last accepted sample
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_marker(input logic [15:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    marker_now = v;
  endtask

  function automatic logic [15:0] pick_sample(input fill_mode_t mode, input logic [15:0] ext,
                                              input logic [15:0] mk);
    logic [15:0] v;
    v = 16'($urandom);
    case (mode)
      FILL_EMPTY:   v = mk;
      FILL_EXTREME: if ($urandom_range(0, 7) != 0) v = ext; else v = mk;
      FILL_SPARSE:  if ($urandom_range(0, 19) != 0) v = mk;
      FILL_FINE:    if ($urandom_range(0, 9) != 0) v = 16'($urandom_range(0, 15)); else v = mk;
      default:      if ($urandom_range(0, 5) == 0) v = mk;
    endcase
    return v;
  endfunction

  // each sector gets its own fill pattern
  task automatic run_random(input int n);
    fill_mode_t  mode;
    logic [15:0] ext;
    int          r;
    mode = FILL_MIXED;
    ext  = 16'hFFFF;
    for (int i = 0; i < n; i++) begin
      if (sent % lsa_pkg::SECTOR_SPAN == 0) begin
        r = $urandom_range(0, 99);
        if (r < 40)      mode = FILL_MIXED;
        else if (r < 55) mode = FILL_EMPTY;
        else if (r < 70) mode = FILL_EXTREME;
        else if (r < 85) mode = FILL_SPARSE;
        else             mode = FILL_FINE;
        ext = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end
      send_sample(pick_sample(mode, ext, marker_now));
    end
  endtask

  initial begin
    logic [15:0] directed [15];
    directed = '{16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 16'h8000, 16'h7FFF, 16'h5555,
                 16'hAAAA, 16'h0001, 16'h0002, 16'h0003, 16'hFFFF, 16'hFFFF, 16'h0000,
                 16'hFFFE};
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_data            = 16'h0000;
    in_chan.valid       = 1'b0;
    in_chan.distance_mm = 16'h0000;
    out_chan.ready      = 1'b0;
    stall_left          = 0;
    sent                = 0;
    calm                = 1'b0;
    marker_now          = lsa_pkg::MARKER_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_sample(directed[i]);
    run_random(400);

    // marker changes land mid-scan and mid-sector
    drain();
    write_marker(16'h0000);
    run_random(400);

    drain();
    write_marker(16'hFFFF);
    run_random(300);

    drain();
    write_marker(16'($urandom_range(1, 65534)));
    run_random(300);

    drain();
    calm = 1'b1;
    write_marker(16'($urandom));
    run_random(300);

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> filelist.f
design/lsa_pkg.sv
design/lsa_if.sv
design/lsa_front.sv
design/lsa_queue.sv
design/lsa_divider.sv
design/lidar_sector_averager_core.sv
test/sector_average_checker.sv
test/testbench.sv
